// File: rtl/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types and constants of the debug packet deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

   // Result kinds.
   localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
   localparam logic [2:0] KIND_GOOD_END = 3'd1;
   localparam logic [2:0] KIND_BAD_END  = 3'd2;
   localparam logic [2:0] KIND_OVERFLOW = 3'd3;
   localparam logic [2:0] KIND_BREAK    = 3'd4;

   // Framing bytes.
   localparam logic [7:0] START_MARK = 8'h24;
   localparam logic [7:0] END_MARK   = 8'h23;
   localparam logic [7:0] BREAK_BYTE = 8'h03;

   localparam int unsigned LIMIT_W     = 9;
   localparam logic [8:0]  LIMIT_RESET = 9'd256;

   // One result as it leaves the framing logic.
   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] computed_sum;
      logic       last;
      logic       break_flag;
   } result_type;

endpackage

// File: rtl/dpd_if.sv
// ----------------------------------------------------------------------------
// dpd_if
// Valid/ready channels of the debug packet deframer.
// ----------------------------------------------------------------------------
interface dpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic [7:0] computed_sum;
   logic       last;
   logic       break_flag;

   modport source (output valid, output kind, output data, output computed_sum,
                   output last, output break_flag, input ready);
   modport sink (input valid, input kind, input data, input computed_sum,
                 input last, input break_flag, output ready);
endinterface

// File: rtl/dpd_frame_fsm.sv
// ----------------------------------------------------------------------------
// dpd_frame_fsm
// Packet framing state and the per-byte result logic.
// ----------------------------------------------------------------------------
module dpd_frame_fsm #(
   parameter int unsigned MAX_PAYLOAD = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic [8:0]          payload_limit,
   output dpd_pkg::result_type result
);
   import dpd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PAYLOAD,
      PH_DIGIT1,
      PH_DIGIT2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [3:0]       nibble_ff, nibble_in;
   logic             digit_err_ff, digit_err_in;

   logic [CMP_W-1:0] limit_ext;
   logic [CMP_W-1:0] max_ext;
   logic [CMP_W-1:0] eff_limit;
   logic [4:0]       hex;
   logic [7:0]       rx_sum;

   // Returns {is_hex, value}; a non-hex byte has value zero.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end
      return r;
   endfunction

   assign limit_ext = CMP_W'(payload_limit);
   assign max_ext   = CMP_W'(MAX_PAYLOAD);
   assign eff_limit = (limit_ext > max_ext) ? max_ext : limit_ext;
   assign hex       = hex_decode(rx_byte);
   assign rx_sum    = {nibble_ff, hex[3:0]};

   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      nibble_in    = nibble_ff;
      digit_err_in = digit_err_ff;
      result       = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == START_MARK) begin
               phase_in     = PH_PAYLOAD;
               sum_in       = 8'd0;
               count_in     = '0;
               nibble_in    = 4'd0;
               digit_err_in = 1'b0;
            end else if (rx_byte == BREAK_BYTE) begin
               result.valid = 1'b1;
               result.kind  = KIND_BREAK;
               result.data  = rx_byte;
               result.last  = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            if (rx_byte == END_MARK) begin
               phase_in = PH_DIGIT1;
            end else if (CMP_W'(count_ff) >= eff_limit) begin
               result.valid        = 1'b1;
               result.kind         = KIND_OVERFLOW;
               result.data         = rx_byte;
               result.computed_sum = sum_ff;
               result.last         = 1'b1;
               phase_in            = PH_IDLE;
            end else begin
               sum_in              = sum_ff + rx_byte;
               count_in            = count_ff + 1'b1;
               result.valid        = 1'b1;
               result.kind         = KIND_PAYLOAD;
               result.data         = rx_byte;
               result.computed_sum = sum_ff + rx_byte;
               result.break_flag   = (rx_byte == BREAK_BYTE);
            end
         end
         PH_DIGIT1: begin
            if (!hex[4]) begin
               digit_err_in = 1'b1;
            end
            nibble_in = hex[3:0];
            phase_in  = PH_DIGIT2;
         end
         PH_DIGIT2: begin
            result.valid        = 1'b1;
            result.kind         = (hex[4] && !digit_err_ff && rx_sum == sum_ff)
                                  ? KIND_GOOD_END : KIND_BAD_END;
            result.data         = rx_sum;
            result.computed_sum = sum_ff;
            result.last         = 1'b1;
            phase_in            = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sum_ff       <= 8'd0;
         count_ff     <= '0;
         nibble_ff    <= 4'd0;
         digit_err_ff <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         nibble_ff    <= nibble_in;
         digit_err_ff <= digit_err_in;
      end
   end

endmodule

// File: rtl/dpd_out_reg.sv
// ----------------------------------------------------------------------------
// dpd_out_reg
// Result register that drives the response channel.
// ----------------------------------------------------------------------------
module dpd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  dpd_pkg::result_type result,
   output logic                can_load,
   dpd_rsp_if.source           rsp_chan
);
   import dpd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The register takes a new value whenever it is empty or being drained.
   assign can_load = !valid_ff || rsp_chan.ready;
   assign valid_in = can_load ? (load_valid && result.valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (can_load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.kind         = data_ff.kind;
   assign rsp_chan.data         = data_ff.data;
   assign rsp_chan.computed_sum = data_ff.computed_sum;
   assign rsp_chan.last         = data_ff.last;
   assign rsp_chan.break_flag   = data_ff.break_flag;

endmodule

// File: rtl/debug_packet_deframer.sv
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Frames $payload#hh debugger packets from a byte stream, one byte a clock unless stalled.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                   Handshake
//  req_chan  in         rx_byte                                   valid/ready
//  rsp_chan  out        kind, data, computed_sum, last, break_flag valid/ready
//  csr       in         payload_limit (csr_wdata)                 csr_we
//
// One byte is accepted every clock while the response channel is not stalled;
// its result passes through the input register and then the result register
// before it is presented on rsp_chan.
// Throughput is set by the single framing update per byte in dpd_frame_fsm.
// A stalled response holds the result register and then the input register;
// req_chan.ready drops only when both are full.
// Reset is synchronous and active high; payload_limit resets to 256.
// ----------------------------------------------------------------------------
module debug_packet_deframer #(
   parameter int unsigned MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   dpd_req_if.sink     req_chan,
   dpd_rsp_if.source   rsp_chan
);
   import dpd_pkg::*;

   logic [8:0] limit_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       can_load;
   logic       step;
   result_type result;

   assign step          = in_valid_ff && can_load;
   assign req_chan.ready = !in_valid_ff || can_load;
   assign in_valid_in   = req_chan.ready ? req_chan.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   dpd_frame_fsm #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .rx_byte       (in_byte_ff),
      .payload_limit (limit_ff),
      .result        (result)
   );

   dpd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .result     (result),
      .can_load   (can_load),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: rtl/dpd_checker.sv
// ----------------------------------------------------------------------------
// dpd_checker
// Port-level checks of the debug packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
module dpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_data,
   input logic [7:0] rsp_computed_sum,
   input logic       rsp_last,
   input logic       rsp_break_flag
);
   import dpd_pkg::*;

   // A pending response transaction is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped before transaction");

   // After reset both registers are empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // Only payload bytes leave a run open, and only they carry the break flag.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_PAYLOAD))
                 && (!rsp_break_flag || rsp_kind == KIND_PAYLOAD))
      else $error("last or break_flag inconsistent with kind");

   // A break outside a packet reports the break byte with a zero sum.
   a_break_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BREAK |->
         rsp_data == BREAK_BYTE && rsp_computed_sum == 8'd0)
      else $error("break result fields wrong");

   // A payload byte equal to the break byte is always flagged.
   a_break_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |->
         rsp_break_flag == (rsp_data == BREAK_BYTE))
      else $error("break_flag does not match payload byte");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_kind         (rsp_chan.kind),
   .rsp_data         (rsp_chan.data),
   .rsp_computed_sum (rsp_chan.computed_sum),
   .rsp_last         (rsp_chan.last),
   .rsp_break_flag   (rsp_chan.break_flag)
);
